// ===== design/pm1d_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pm1d_pkg
// Shared types and codes for the 1-D PatchMatch K-neighbor field block.
// ----------------------------------------------------------------------------
package pm1d_pkg;

    // request action codes
    localparam logic [2:0] ACT_QUERY_FEAT = 3'd0;
    localparam logic [2:0] ACT_REF_FEAT   = 3'd1;
    localparam logic [2:0] ACT_INIT_NBR   = 3'd2;
    localparam logic [2:0] ACT_RANDOM     = 3'd3;
    localparam logic [2:0] ACT_RUN        = 3'd4;
    localparam logic [2:0] ACT_READ_NBR   = 3'd5;

    // configuration register indexes
    localparam logic [2:0] CFG_QUERY_ROWS = 3'd0;
    localparam logic [2:0] CFG_REF_ROWS   = 3'd1;
    localparam logic [2:0] CFG_DIMS       = 3'd2;
    localparam logic [2:0] CFG_NEIGHBORS  = 3'd3;
    localparam logic [2:0] CFG_ITERS      = 3'd4;
    localparam logic [2:0] CFG_DIST_KIND  = 3'd5;

    // datapath widths
    localparam int DIST_W   = 38;
    localparam int ROW1_W   = 9;
    localparam int NBE_W    = ROW1_W + DIST_W;
    localparam int PROD_W   = 26;
    localparam int CV_W     = 14;
    localparam int COUNT_W  = 17;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD_WAIT,
        ST_LOAD,
        ST_LOAD_WAIT,
        ST_INIT_SLOT,
        ST_PROP,
        ST_RND_READ,
        ST_RND_WAIT,
        ST_RND_SCALE,
        ST_RND_STEP,
        ST_RND_CAND,
        ST_EV_ISSUE,
        ST_EV_DRAIN,
        ST_STORE
    } pm1d_state_t;

endpackage

// ===== design/pm1d_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pm1d_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module pm1d_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/patchmatch_1d_knn_field.sv =====
`timescale 1ns / 1ps
// A load, a rejected request or an unknown action gives its result in the cycle after
// acceptance; a neighbor read first passes ST_RD_WAIT (neighbor memory read port).
// A run scores the stored neighbors first, then does propagation and random search
// row by row for each pass; each distance evaluation reads one feature of each row
// per step through the one read port of each feature memory. Reset (asynchronous,
// active low) clears control, counters and configuration, not memories.
// ----------------------------------------------------------------------------
// patchmatch_1d_knn_field
// PatchMatch approximate K-nearest-neighbor field over 1-D rows of features,
// with propagation and random search over memories holding the neighbor lists.
// ----------------------------------------------------------------------------
module patchmatch_1d_knn_field
    import pm1d_pkg::*;
#(
    parameter int MAX_QUERY_ROWS = 256,
    parameter int MAX_REF_ROWS   = 256,
    parameter int MAX_DIMS       = 16,
    parameter int MAX_NEIGHBORS  = 4,
    parameter int MAX_ITERS      = 8
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [2:0]         action,
    input  logic [7:0]         row,
    input  logic [3:0]         column,
    input  logic signed [15:0] value,
    input  logic [8:0]         init_neighbor,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [8:0]         neighbor_index,
    output logic [16:0]        query_count,
    output logic               status,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [8:0]         cfg_data
);

    localparam int QR_W = $clog2(MAX_QUERY_ROWS);
    localparam int RR_W = $clog2(MAX_REF_ROWS);
    localparam int DM_W = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
    localparam int NB_W = (MAX_NEIGHBORS > 1) ? $clog2(MAX_NEIGHBORS) : 1;
    localparam int IT_W = (MAX_ITERS > 1) ? $clog2(MAX_ITERS) : 1;
    localparam int QF_DEPTH = MAX_QUERY_ROWS * MAX_DIMS;
    localparam int RF_DEPTH = MAX_REF_ROWS * MAX_DIMS;
    localparam int NB_DEPTH = MAX_QUERY_ROWS * MAX_NEIGHBORS;
    localparam int RO_DEPTH = MAX_QUERY_ROWS * MAX_ITERS;
    localparam int QF_AW = $clog2(QF_DEPTH);
    localparam int RF_AW = $clog2(RF_DEPTH);
    localparam int NB_AW = $clog2(NB_DEPTH);
    localparam int RO_AW = $clog2(RO_DEPTH);
    localparam logic [8:0] QROWS_RST = 9'((MAX_QUERY_ROWS < 256) ? MAX_QUERY_ROWS : 256);
    localparam logic [8:0] RROWS_RST = 9'((MAX_REF_ROWS < 256) ? MAX_REF_ROWS : 256);
    localparam logic [4:0] DIMS_RST  = 5'((MAX_DIMS < 16) ? MAX_DIMS : 16);
    localparam logic [2:0] NBR_RST   = 3'((MAX_NEIGHBORS < 4) ? MAX_NEIGHBORS : 4);

    pm1d_state_t state_reg, state_next, ret_reg, ret_next;

    logic             phase_init_reg, phase_init_next;
    logic [QR_W-1:0]  row_reg, row_next;
    logic [NB_W-1:0]  k_reg, k_next;
    logic [DM_W-1:0]  d_reg, d_next;
    logic [IT_W-1:0]  it_reg, it_next;
    logic [3:0]       r_reg, r_next;
    logic [3:0]       nr_reg, nr_next;
    logic [COUNT_W-1:0] count_reg, count_next;

    logic [8:0] qrows_reg, rrows_reg;
    logic [4:0] dims_reg;
    logic [2:0] nbr_reg;
    logic [3:0] iters_reg;
    logic       dkind_reg;

    logic       out_valid_reg, out_valid_next;
    logic [8:0] nidx_reg, nidx_next;
    logic       status_reg, status_next;

    logic [ROW1_W-1:0] list_row_reg [MAX_NEIGHBORS];
    logic [ROW1_W-1:0] list_row_next [MAX_NEIGHBORS];
    logic [DIST_W-1:0] list_dist_reg [MAX_NEIGHBORS];
    logic [DIST_W-1:0] list_dist_next [MAX_NEIGHBORS];
    logic [ROW1_W-1:0] prev_row_reg [MAX_NEIGHBORS];
    logic [ROW1_W-1:0] prev_row_next [MAX_NEIGHBORS];
    logic [ROW1_W-1:0] cand_row_reg [MAX_NEIGHBORS];
    logic [ROW1_W-1:0] cand_row_next [MAX_NEIGHBORS];
    logic [ROW1_W-1:0] offer_row [MAX_NEIGHBORS];
    logic [DIST_W-1:0] offer_dist [MAX_NEIGHBORS];

    logic [RR_W-1:0]   ev_ref_reg, ev_ref_next;
    logic [ROW1_W-1:0] ev_row1_reg, ev_row1_next;
    logic [NB_W-1:0]   ev_slot_reg, ev_slot_next;
    logic              ev_init_reg, ev_init_next;

    logic              rd_v_reg, ad_v_reg, term_v_reg;
    logic [15:0]       ad_reg;
    logic [31:0]       term_reg;
    logic [DIST_W-1:0] acc_reg, acc_next;

    logic [PROD_W-1:0]     prod_reg, prod_next;
    logic                  neg_reg, neg_next;
    logic signed [CV_W-1:0] dr_reg, dr_next;

    logic             qf_we, rf_we, ro_we, nb_we;
    logic [QF_AW-1:0] qf_waddr, qf_raddr;
    logic [RF_AW-1:0] rf_waddr, rf_raddr;
    logic [RO_AW-1:0] ro_waddr, ro_raddr;
    logic [NB_AW-1:0] nb_in_addr, nb_cur_addr, nb_waddr, nb_raddr;
    logic [15:0]      qf_rdata, rf_rdata, ro_rdata;
    logic [NBE_W-1:0] nb_wdata, nb_rdata;

    logic in_fire, last_k, last_row, last_d, last_it, run_done;
    logic in_q_ok, in_r_ok, dim_ok, slot_ok, iter_ok;
    logic [ROW1_W-1:0]      src_row;
    logic signed [CV_W-1:0] cand_val;
    logic cand_ok, eval_go, drain_done;
    logic signed [16:0] fdiff;
    logic [16:0]        fmag;
    logic signed [16:0] rv17;
    logic [16:0]        rmag;
    logic [4:0]         prod_bits;
    logic [3:0]         nr_calc;
    logic [4:0]         shift_amt;
    logic [PROD_W-1:0]  shifted, low_mask;
    logic [CV_W-1:0]    dr_mag;
    logic               ins_found;
    logic [NB_W-1:0]    ins_pos;

    // ------------------------------------------------------------------------
    // memories
    // ------------------------------------------------------------------------
    pm1d_ram #(.WIDTH(16), .DEPTH(QF_DEPTH)) u_qf_ram (
        .clk(clk), .we(qf_we), .waddr(qf_waddr), .wdata(value),
        .raddr(qf_raddr), .rdata(qf_rdata)
    );

    pm1d_ram #(.WIDTH(16), .DEPTH(RF_DEPTH)) u_rf_ram (
        .clk(clk), .we(rf_we), .waddr(rf_waddr), .wdata(value),
        .raddr(rf_raddr), .rdata(rf_rdata)
    );

    pm1d_ram #(.WIDTH(16), .DEPTH(RO_DEPTH)) u_ro_ram (
        .clk(clk), .we(ro_we), .waddr(ro_waddr), .wdata(value),
        .raddr(ro_raddr), .rdata(ro_rdata)
    );

    pm1d_ram #(.WIDTH(NBE_W), .DEPTH(NB_DEPTH)) u_nb_ram (
        .clk(clk), .we(nb_we), .waddr(nb_waddr), .wdata(nb_wdata),
        .raddr(nb_raddr), .rdata(nb_rdata)
    );

    // ------------------------------------------------------------------------
    // shared decode
    // ------------------------------------------------------------------------
    assign in_ready  = (state_reg == ST_IDLE) && (!out_valid_reg || out_ready);
    assign in_fire   = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign neighbor_index = nidx_reg;
    assign status    = status_reg;
    assign query_count = count_reg;

    assign in_q_ok = {1'b0, row} < qrows_reg;
    assign in_r_ok = {1'b0, row} < rrows_reg;
    assign dim_ok  = {1'b0, column} < dims_reg;
    assign slot_ok = {1'b0, column} < {2'b0, nbr_reg};
    assign iter_ok = column < iters_reg;

    assign last_k   = (k_reg == NB_W'(nbr_reg - 3'd1));
    assign last_row = (row_reg == QR_W'(qrows_reg - 9'd1));
    assign last_d   = (d_reg == DM_W'(dims_reg - 5'd1));
    assign last_it  = (it_reg == IT_W'(iters_reg - 4'd1));
    assign run_done = last_k && last_row
                      && ((phase_init_reg && (iters_reg == 4'd0))
                          || (!phase_init_reg && last_it));

    assign qf_waddr = QF_AW'(int'(row) * MAX_DIMS + int'(column));
    assign rf_waddr = RF_AW'(int'(row) * MAX_DIMS + int'(column));
    assign ro_waddr = RO_AW'(int'(row) * MAX_ITERS + int'(column));
    assign nb_in_addr  = NB_AW'(int'(row) * MAX_NEIGHBORS + int'(column));
    assign nb_cur_addr = NB_AW'(int'(row_reg) * MAX_NEIGHBORS + int'(k_reg));
    assign qf_raddr = QF_AW'(int'(row_reg) * MAX_DIMS + int'(d_reg));
    assign rf_raddr = RF_AW'(int'(ev_ref_reg) * MAX_DIMS + int'(d_reg));
    assign ro_raddr = RO_AW'(int'(row_reg) * MAX_ITERS + int'(it_reg));
    assign nb_raddr = (state_reg == ST_IDLE) ? nb_in_addr : nb_cur_addr;
    assign nb_waddr = (state_reg == ST_IDLE) ? nb_in_addr : nb_cur_addr;
    assign nb_wdata = (state_reg == ST_IDLE) ? {init_neighbor, DIST_W'(0)}
                                             : {list_row_reg[k_reg], list_dist_reg[k_reg]};

    // pick the candidate source of the current step
    always_comb
    begin
        unique case (state_reg)
            ST_PROP:
            begin
                src_row  = prev_row_reg[k_reg];
                cand_val = $signed({5'b0, src_row}) + 14'sd1;
            end
            ST_RND_CAND:
            begin
                src_row  = cand_row_reg[k_reg];
                cand_val = $signed({5'b0, src_row}) + dr_reg;
            end
            default:
            begin
                src_row  = list_row_reg[k_reg];
                cand_val = $signed({5'b0, src_row});
            end
        endcase
    end

    assign cand_ok = (src_row != '0) && (cand_val >= 14'sd1)
                     && (cand_val <= $signed({5'b0, rrows_reg}));
    assign eval_go = cand_ok && ((state_reg == ST_INIT_SLOT) || (state_reg == ST_RND_CAND)
                                 || ((state_reg == ST_PROP) && (row_reg != '0)));
    assign drain_done = (state_reg == ST_EV_DRAIN) && !rd_v_reg && !ad_v_reg && !term_v_reg;

    // feature difference magnitude
    assign fdiff = $signed({qf_rdata[15], qf_rdata}) - $signed({rf_rdata[15], rf_rdata});
    assign fmag  = fdiff[16] ? 17'(-fdiff) : 17'(fdiff);

    // random value magnitude
    assign rv17 = $signed({ro_rdata[15], ro_rdata});
    assign rmag = rv17[16] ? 17'(-rv17) : 17'(rv17);

    // search radius count from the scaled random value
    always_comb
    begin
        prod_bits = 5'd0;
        for (int b = 0; b < PROD_W; b++)
        begin
            if (prod_reg[b])
            begin
                prod_bits = 5'(b + 1);
            end
        end
        nr_calc = (prod_bits >= 5'd16) ? 4'(prod_bits - 5'd16) : 4'd0;
    end

    // offset for the current radius, rounded toward minus infinity
    assign shift_amt = 5'd15 + {1'b0, r_reg};
    assign shifted   = prod_reg >> shift_amt;
    assign low_mask  = ~({PROD_W{1'b1}} << shift_amt);
    assign dr_mag    = CV_W'(shifted) + CV_W'(neg_reg & (|(prod_reg & low_mask)));

    // stable insertion of the finished candidate into the live list
    always_comb
    begin
        ins_found = 1'b0;
        ins_pos   = '0;
        for (int j = 0; j < MAX_NEIGHBORS; j++)
        begin
            if (!ins_found && (j < int'(nbr_reg))
                && ((list_row_reg[j] == '0) || (list_dist_reg[j] > acc_reg)))
            begin
                ins_found = 1'b1;
                ins_pos   = NB_W'(j);
            end
        end
        for (int j = 0; j < MAX_NEIGHBORS; j++)
        begin
            if (ins_found && (j == int'(ins_pos)))
            begin
                offer_row[j]  = ev_row1_reg;
                offer_dist[j] = acc_reg;
            end
            else if (ins_found && (j > int'(ins_pos)))
            begin
                offer_row[j]  = list_row_reg[(j > 0) ? j - 1 : 0];
                offer_dist[j] = list_dist_reg[(j > 0) ? j - 1 : 0];
            end
            else
            begin
                offer_row[j]  = list_row_reg[j];
                offer_dist[j] = list_dist_reg[j];
            end
        end
    end

    // ------------------------------------------------------------------------
    // next state
    // ------------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        ret_next   = ret_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire && (action == ACT_RUN))
                begin
                    state_next = ST_LOAD;
                end
                else if (in_fire && (action == ACT_READ_NBR) && in_q_ok && slot_ok)
                begin
                    state_next = ST_RD_WAIT;
                end
            end
            ST_RD_WAIT:
            begin
                state_next = ST_IDLE;
            end
            ST_LOAD:
            begin
                state_next = ST_LOAD_WAIT;
            end
            ST_LOAD_WAIT:
            begin
                if (last_k)
                begin
                    state_next = phase_init_reg ? ST_INIT_SLOT : ST_PROP;
                end
                else
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_INIT_SLOT:
            begin
                if (eval_go)
                begin
                    state_next = ST_EV_ISSUE;
                    ret_next   = last_k ? ST_STORE : ST_INIT_SLOT;
                end
                else if (last_k)
                begin
                    state_next = ST_STORE;
                end
            end
            ST_PROP:
            begin
                if (row_reg == '0)
                begin
                    state_next = ST_RND_READ;
                end
                else if (eval_go)
                begin
                    state_next = ST_EV_ISSUE;
                    ret_next   = last_k ? ST_RND_READ : ST_PROP;
                end
                else if (last_k)
                begin
                    state_next = ST_RND_READ;
                end
            end
            ST_RND_READ:
            begin
                state_next = ST_RND_WAIT;
            end
            ST_RND_WAIT:
            begin
                state_next = ST_RND_SCALE;
            end
            ST_RND_SCALE:
            begin
                state_next = ST_RND_STEP;
            end
            ST_RND_STEP:
            begin
                state_next = (r_reg < nr_reg) ? ST_RND_CAND : ST_STORE;
            end
            ST_RND_CAND:
            begin
                if (eval_go)
                begin
                    state_next = ST_EV_ISSUE;
                    ret_next   = last_k ? ST_RND_STEP : ST_RND_CAND;
                end
                else if (last_k)
                begin
                    state_next = ST_RND_STEP;
                end
            end
            ST_EV_ISSUE:
            begin
                if (last_d)
                begin
                    state_next = ST_EV_DRAIN;
                end
            end
            ST_EV_DRAIN:
            begin
                if (drain_done)
                begin
                    state_next = ret_reg;
                end
            end
            ST_STORE:
            begin
                if (run_done)
                begin
                    state_next = ST_IDLE;
                end
                else if (last_k)
                begin
                    state_next = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------------
    // datapath and memory controls
    // ------------------------------------------------------------------------
    always_comb
    begin
        phase_init_next = phase_init_reg;
        row_next        = row_reg;
        k_next          = k_reg;
        d_next          = d_reg;
        it_next         = it_reg;
        r_next          = r_reg;
        nr_next         = nr_reg;
        count_next      = count_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        nidx_next       = nidx_reg;
        status_next     = status_reg;
        list_row_next   = list_row_reg;
        list_dist_next  = list_dist_reg;
        prev_row_next   = prev_row_reg;
        cand_row_next   = cand_row_reg;
        ev_ref_next     = ev_ref_reg;
        ev_row1_next    = ev_row1_reg;
        ev_slot_next    = ev_slot_reg;
        ev_init_next    = ev_init_reg;
        prod_next       = prod_reg;
        neg_next        = neg_reg;
        dr_next         = dr_reg;
        qf_we           = 1'b0;
        rf_we           = 1'b0;
        ro_we           = 1'b0;
        nb_we           = 1'b0;

        // start a distance evaluation
        if (eval_go)
        begin
            ev_ref_next  = RR_W'(cand_val - 14'sd1);
            ev_row1_next = ROW1_W'(cand_val);
            ev_slot_next = k_reg;
            ev_init_next = (state_reg == ST_INIT_SLOT);
            d_next       = '0;
            if ((state_reg != ST_INIT_SLOT) && (count_reg != COUNT_MAX))
            begin
                count_next = count_reg + 1'b1;
            end
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    out_valid_next = 1'b1;
                    nidx_next      = '0;
                    status_next    = 1'b0;
                    unique case (action)
                        ACT_QUERY_FEAT:
                        begin
                            qf_we       = in_q_ok && dim_ok;
                            status_next = !(in_q_ok && dim_ok);
                        end
                        ACT_REF_FEAT:
                        begin
                            rf_we       = in_r_ok && dim_ok;
                            status_next = !(in_r_ok && dim_ok);
                        end
                        ACT_INIT_NBR:
                        begin
                            nb_we       = in_q_ok && slot_ok;
                            status_next = !(in_q_ok && slot_ok);
                        end
                        ACT_RANDOM:
                        begin
                            ro_we       = in_q_ok && iter_ok;
                            status_next = !(in_q_ok && iter_ok);
                        end
                        ACT_RUN:
                        begin
                            out_valid_next  = 1'b0;
                            count_next      = '0;
                            row_next        = '0;
                            k_next          = '0;
                            phase_init_next = 1'b1;
                        end
                        ACT_READ_NBR:
                        begin
                            out_valid_next = !(in_q_ok && slot_ok);
                            status_next    = 1'b1;
                        end
                        default:
                        begin
                            status_next = 1'b0;
                        end
                    endcase
                end
            end
            ST_RD_WAIT:
            begin
                out_valid_next = 1'b1;
                nidx_next      = nb_rdata[NBE_W-1:DIST_W];
                status_next    = 1'b0;
            end
            ST_LOAD_WAIT:
            begin
                list_row_next[k_reg]  = nb_rdata[NBE_W-1:DIST_W];
                list_dist_next[k_reg] = nb_rdata[DIST_W-1:0];
                k_next = last_k ? '0 : k_reg + 1'b1;
            end
            ST_INIT_SLOT:
            begin
                // drop a neighbor outside the reference rows
                if (!eval_go)
                begin
                    list_row_next[k_reg]  = '0;
                    list_dist_next[k_reg] = '0;
                end
                k_next = last_k ? '0 : k_reg + 1'b1;
            end
            ST_PROP:
            begin
                if (row_reg != '0)
                begin
                    k_next = last_k ? '0 : k_reg + 1'b1;
                end
            end
            ST_RND_WAIT:
            begin
                prod_next     = PROD_W'(rmag) * PROD_W'(rrows_reg);
                neg_next      = ro_rdata[15];
                cand_row_next = list_row_reg;
            end
            ST_RND_SCALE:
            begin
                nr_next = nr_calc;
                r_next  = '0;
            end
            ST_RND_STEP:
            begin
                dr_next = neg_reg ? -$signed(dr_mag) : $signed(dr_mag);
                k_next  = '0;
            end
            ST_RND_CAND:
            begin
                k_next = last_k ? '0 : k_reg + 1'b1;
                if (last_k)
                begin
                    r_next = r_reg + 1'b1;
                end
            end
            ST_EV_ISSUE:
            begin
                d_next = last_d ? '0 : d_reg + 1'b1;
            end
            ST_EV_DRAIN:
            begin
                if (drain_done && ev_init_reg)
                begin
                    list_dist_next[ev_slot_reg] = acc_reg;
                end
                else if (drain_done)
                begin
                    list_row_next  = offer_row;
                    list_dist_next = offer_dist;
                end
            end
            ST_STORE:
            begin
                nb_we  = 1'b1;
                k_next = last_k ? '0 : k_reg + 1'b1;
                if (last_k)
                begin
                    prev_row_next = list_row_reg;
                    row_next      = last_row ? '0 : row_reg + 1'b1;
                    if (last_row && phase_init_reg)
                    begin
                        phase_init_next = 1'b0;
                        it_next         = '0;
                    end
                    else if (last_row)
                    begin
                        it_next = it_reg + 1'b1;
                    end
                end
                if (run_done)
                begin
                    out_valid_next = 1'b1;
                    nidx_next      = '0;
                    status_next    = 1'b0;
                end
            end
            default:
            begin
            end
        endcase
    end

    // accumulate the distance terms
    always_comb
    begin
        acc_next = acc_reg;
        if (eval_go)
        begin
            acc_next = '0;
        end
        else if (term_v_reg)
        begin
            acc_next = acc_reg + DIST_W'(term_reg);
        end
    end

    // ------------------------------------------------------------------------
    // control registers
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            ret_reg        <= ST_IDLE;
            phase_init_reg <= 1'b0;
            row_reg        <= '0;
            k_reg          <= '0;
            d_reg          <= '0;
            it_reg         <= '0;
            r_reg          <= '0;
            nr_reg         <= '0;
            count_reg      <= '0;
            out_valid_reg  <= 1'b0;
            rd_v_reg       <= 1'b0;
            ad_v_reg       <= 1'b0;
            term_v_reg     <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            ret_reg        <= ret_next;
            phase_init_reg <= phase_init_next;
            row_reg        <= row_next;
            k_reg          <= k_next;
            d_reg          <= d_next;
            it_reg         <= it_next;
            r_reg          <= r_next;
            nr_reg         <= nr_next;
            count_reg      <= count_next;
            out_valid_reg  <= out_valid_next;
            rd_v_reg       <= (state_reg == ST_EV_ISSUE);
            ad_v_reg       <= rd_v_reg;
            term_v_reg     <= ad_v_reg;
        end
    end

    // configuration registers, saturated into range on write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qrows_reg <= QROWS_RST;
            rrows_reg <= RROWS_RST;
            dims_reg  <= DIMS_RST;
            nbr_reg   <= NBR_RST;
            iters_reg <= 4'd1;
            dkind_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_QUERY_ROWS:
                begin
                    qrows_reg <= (cfg_data == 9'd0) ? 9'd1
                               : (int'(cfg_data) > MAX_QUERY_ROWS) ? 9'(MAX_QUERY_ROWS)
                               : cfg_data;
                end
                CFG_REF_ROWS:
                begin
                    rrows_reg <= (cfg_data == 9'd0) ? 9'd1
                               : (int'(cfg_data) > MAX_REF_ROWS) ? 9'(MAX_REF_ROWS)
                               : cfg_data;
                end
                CFG_DIMS:
                begin
                    dims_reg <= (cfg_data[4:0] == 5'd0) ? 5'd1
                              : (int'(cfg_data[4:0]) > MAX_DIMS) ? 5'(MAX_DIMS)
                              : cfg_data[4:0];
                end
                CFG_NEIGHBORS:
                begin
                    nbr_reg <= (cfg_data[2:0] == 3'd0) ? 3'd1
                             : (int'(cfg_data[2:0]) > MAX_NEIGHBORS) ? 3'(MAX_NEIGHBORS)
                             : cfg_data[2:0];
                end
                CFG_ITERS:
                begin
                    iters_reg <= (int'(cfg_data[3:0]) > MAX_ITERS) ? 4'(MAX_ITERS)
                               : cfg_data[3:0];
                end
                CFG_DIST_KIND:
                begin
                    dkind_reg <= cfg_data[0];
                end
                default:
                begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // payload registers
    // ------------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        nidx_reg      <= nidx_next;
        status_reg    <= status_next;
        list_row_reg  <= list_row_next;
        list_dist_reg <= list_dist_next;
        prev_row_reg  <= prev_row_next;
        cand_row_reg  <= cand_row_next;
        ev_ref_reg    <= ev_ref_next;
        ev_row1_reg   <= ev_row1_next;
        ev_slot_reg   <= ev_slot_next;
        ev_init_reg   <= ev_init_next;
        prod_reg      <= prod_next;
        neg_reg       <= neg_next;
        dr_reg        <= dr_next;
        acc_reg       <= acc_next;
        ad_reg        <= fmag[15:0];
        term_reg      <= dkind_reg ? (32'(ad_reg) * 32'(ad_reg)) : 32'(ad_reg);
    end

`ifndef ASSERT_OFF
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> (state_reg == ST_IDLE))
        else $error("request taken outside idle");

    a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_IDLE) && !in_fire) |=> $stable(count_reg))
        else $error("evaluation count moved while idle");

    a_pipe_in_eval: assert property (@(posedge clk) disable iff (!rst_n)
        (ad_v_reg || term_v_reg) |-> ((state_reg == ST_EV_ISSUE) || (state_reg == ST_EV_DRAIN)))
        else $error("distance pipeline busy outside an evaluation");

    a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (state_reg == ST_IDLE))
        else $error("result pending while a request is at work");

    a_radius_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RND_STEP) |-> (int'(nr_reg) <= PROD_W - 16))
        else $error("search radius count out of range");
`endif

endmodule

// ===== bench/pm1d_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pm1d_checker
// Watches the request, result and register ports of the PatchMatch block,
// predicts every result from its own copy of the memories and settings,
// and compares each returned result field by field in order.
// ----------------------------------------------------------------------------
module pm1d_checker
    import pm1d_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic [2:0]         action,
    input  logic [7:0]         row,
    input  logic [3:0]         column,
    input  logic [15:0]        value,
    input  logic [8:0]         init_neighbor,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic [8:0]         neighbor_index,
    input  logic [16:0]        query_count,
    input  logic               status,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [8:0]         cfg_data,
    output int                 fail_count,
    output int                 pending
);

    localparam int NQ = 256;
    localparam int NR = 256;
    localparam int ND = 16;
    localparam int NK = 4;
    localparam int NI = 8;

    typedef struct packed {
        logic [8:0]  nbr;
        logic [16:0] cnt;
        logic        st;
    } reply_t;

    reply_t replies_due[$];

    logic [15:0]       qfeat [NQ*ND];
    logic [15:0]       rfeat [NR*ND];
    logic [8:0]        nrow  [NQ*NK];
    logic [DIST_W-1:0] ndist [NQ*NK];
    logic [15:0]       rnd   [NQ*NI];

    int unsigned q_rows, r_rows, dims, nbrs, iters, evals;
    bit          l2;

    function automatic int unsigned sat(int unsigned v, int unsigned lo, int unsigned hi);
        if (v < lo)
            return lo;
        if (v > hi)
            return hi;
        return v;
    endfunction

    // L1 or squared L2 distance of query row q to zero-based reference row r
    function automatic logic [DIST_W-1:0] row_dist(int unsigned q, int unsigned r);
        longint acc;
        longint a;
        longint b;
        longint df;
        acc = 0;
        for (int k = 0; k < dims; k++)
        begin
            a = $signed(qfeat[q*ND+k]);
            b = $signed(rfeat[r*ND+k]);
            df = a - b;
            if (df < 0)
                df = -df;
            acc += l2 ? df * df : df;
        end
        return acc[DIST_W-1:0];
    endfunction

    // insert a candidate after every entry no farther than it
    function automatic void offer(int unsigned q, logic [8:0] row1, logic [DIST_W-1:0] d);
        int unsigned p;
        p = 0;
        while (p < nbrs && nrow[q*NK+p] != 0 && ndist[q*NK+p] <= d)
            p++;
        if (p >= nbrs)
            return;
        for (int k = nbrs - 1; k > p; k--)
        begin
            nrow[q*NK+k]  = nrow[q*NK+k-1];
            ndist[q*NK+k] = ndist[q*NK+k-1];
        end
        nrow[q*NK+p]  = row1;
        ndist[q*NK+p] = d;
    endfunction

    function automatic void try_candidate(int unsigned q, longint c);
        if (c < 1 || c > r_rows)
            return;
        if (evals < COUNT_MAX)
            evals++;
        offer(q, c[8:0], row_dist(q, c - 1));
    endfunction

    function automatic void search_field();
        logic [8:0] snap [NK];
        longint     v;
        longint     mag;
        longint     prod;
        longint     dr;
        int         bits;
        int         nr;
        int         s;
        evals = 0;
        // score the stored neighbors, drop the bad ones
        for (int i = 0; i < q_rows; i++)
            for (int k = 0; k < nbrs; k++)
            begin
                if (nrow[i*NK+k] == 0 || nrow[i*NK+k] > r_rows)
                begin
                    nrow[i*NK+k]  = '0;
                    ndist[i*NK+k] = '0;
                end
                else
                    ndist[i*NK+k] = row_dist(i, nrow[i*NK+k] - 1);
            end
        for (int it = 0; it < iters; it++)
            for (int i = 0; i < q_rows; i++)
            begin
                // propagate from the previous row
                if (i > 0)
                    for (int k = 0; k < nbrs; k++)
                        if (nrow[(i-1)*NK+k] != 0)
                            try_candidate(i, longint'(nrow[(i-1)*NK+k]) + 1);
                // random search around a snapshot of the list
                v = $signed(rnd[i*NI+it]);
                mag = (v < 0) ? -v : v;
                prod = mag * r_rows;
                bits = 0;
                while (bits < 63 && (prod >> bits) != 0)
                    bits++;
                nr = (prod >= 32768) ? bits - 16 : 0;
                for (int k = 0; k < nbrs; k++)
                    snap[k] = nrow[i*NK+k];
                for (int r = 0; r < nr; r++)
                begin
                    s = 15 + r;
                    if (v >= 0)
                        dr = prod >> s;
                    else
                        dr = -((prod + (longint'(1) << s) - 1) >> s);
                    for (int k = 0; k < nbrs; k++)
                        if (snap[k] != 0)
                            try_candidate(i, longint'(snap[k]) + dr);
                end
            end
    endfunction

    function automatic reply_t predict_reply(logic [2:0] a, logic [7:0] r, logic [3:0] c,
                                             logic [15:0] v, logic [8:0] n);
        reply_t res;
        res = '0;
        case (a)
            ACT_QUERY_FEAT:
                if (r < q_rows && c < dims)
                    qfeat[r*ND+c] = v;
                else
                    res.st = 1'b1;
            ACT_REF_FEAT:
                if (r < r_rows && c < dims)
                    rfeat[r*ND+c] = v;
                else
                    res.st = 1'b1;
            ACT_INIT_NBR:
                if (r < q_rows && c < nbrs)
                    nrow[r*NK+c] = n;
                else
                    res.st = 1'b1;
            ACT_RANDOM:
                if (r < q_rows && c < iters)
                    rnd[r*NI+c] = v;
                else
                    res.st = 1'b1;
            ACT_RUN:
                search_field();
            ACT_READ_NBR:
                if (r < q_rows && c < nbrs)
                    res.nbr = nrow[r*NK+c];
                else
                    res.st = 1'b1;
            default: ;
        endcase
        res.cnt = evals[16:0];
        return res;
    endfunction

    assign pending = replies_due.size();

    always @(posedge clk or negedge rst_n)
    begin
        reply_t got;
        reply_t want;
        if (!rst_n)
        begin
            q_rows = 256;
            r_rows = 256;
            dims   = 16;
            nbrs   = 4;
            iters  = 1;
            l2     = 1'b0;
            evals  = 0;
            fail_count <= 0;
            replies_due.delete();
        end
        else
        begin
            // compare a returned result with the oldest prediction
            if (out_valid && out_ready)
            begin
                got = '{neighbor_index, query_count, status};
                if (replies_due.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("%0t: unexpected result nbr=%0d cnt=%0d st=%0d",
                                 $realtime, got.nbr, got.cnt, got.st);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = replies_due.pop_front();
                    if (got !== want)
                    begin
                        if (fail_count < 10)
                            $display("%0t: mismatch exp nbr=%0d cnt=%0d st=%0d got nbr=%0d cnt=%0d st=%0d",
                                     $realtime, want.nbr, want.cnt, want.st,
                                     got.nbr, got.cnt, got.st);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            // track register writes
            if (cfg_we)
                case (cfg_index)
                    CFG_QUERY_ROWS: q_rows = sat(cfg_data, 1, NQ);
                    CFG_REF_ROWS:   r_rows = sat(cfg_data, 1, NR);
                    CFG_DIMS:       dims   = sat(cfg_data[4:0], 1, ND);
                    CFG_NEIGHBORS:  nbrs   = sat(cfg_data[2:0], 1, NK);
                    CFG_ITERS:      iters  = sat(cfg_data[3:0], 0, NI);
                    CFG_DIST_KIND:  l2     = cfg_data[0];
                    default: ;
                endcase
            // predict an accepted request
            if (in_valid && in_ready)
                replies_due.push_back(predict_reply(action, row, column, value, init_neighbor));
        end
    end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives load, run and read requests into the PatchMatch block through
// several register settings, with random gaps and stalls on both sides,
// and reports the verdict from the checker's failure count.
// ----------------------------------------------------------------------------
module tb;
    import pm1d_pkg::*;

    localparam int WATCHDOG_LIMIT = 200000;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [2:0]         action = '0;
    logic [7:0]         row = '0;
    logic [3:0]         column = '0;
    logic signed [15:0] value = '0;
    logic [8:0]         init_neighbor = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [8:0]         neighbor_index;
    logic [16:0]        query_count;
    logic               status;
    logic               cfg_we = 1'b0;
    logic [2:0]         cfg_index = '0;
    logic [8:0]         cfg_data = '0;
    int                 fail_count;
    int                 pending;

    int unsigned q_cfg, r_cfg, d_cfg, k_cfg, i_cfg;
    int          requests_sent = 0;
    int          idle_cycles = 0;
    bit          steady = 1'b0;
    bit          long_hold_done = 1'b0;

    patchmatch_1d_knn_field u_top (.*);

    pm1d_checker u_checker (.*);

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // stall the result side at random, once for a long stretch
    always
    begin
        int gap;
        @(posedge clk);
        if (rst_n)
        begin
            if (!long_hold_done && requests_sent > 200)
            begin
                out_ready <= 1'b0;
                repeat (500) @(posedge clk);
                long_hold_done = 1'b1;
            end
            gap = (steady || $urandom_range(0, 99) < 50) ? 0 :
                  ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            repeat ($urandom_range(0, 15)) @(posedge clk);
        end
    end

    // end the run when nothing moves for too long
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic int unsigned sat(int unsigned v, int unsigned lo, int unsigned hi);
        return (v < lo) ? lo : (v > hi) ? hi : v;
    endfunction

    function automatic logic [15:0] sample_value();
        case ($urandom_range(0, 9))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [8:0] pick_neighbor();
        if ($urandom_range(0, 9) == 0)
            return ($urandom_range(0, 1) != 0) ? 9'd0 : 9'($urandom_range(r_cfg, 511));
        return 9'($urandom_range(1, r_cfg));
    endfunction

    // offer one request and hold it until accepted
    task automatic send(logic [2:0] a, logic [7:0] r, logic [3:0] c, logic [15:0] v,
                        logic [8:0] n);
        int gap;
        gap = steady ? 0 :
              ($urandom_range(0, 99) < 55) ? 0 :
              ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        action        <= a;
        row           <= r;
        column        <= c;
        value         <= v;
        init_neighbor <= n;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        requests_sent++;
    endtask

    // an access beyond the configured size, or an unknown action
    task automatic send_noise();
        logic [2:0]  a;
        int unsigned rlim;
        int unsigned clim;
        if ($urandom_range(0, 3) == 0)
        begin
            send(($urandom_range(0, 1) != 0) ? 3'd6 : 3'd7, 8'($urandom), 4'($urandom),
                 16'($urandom), 9'($urandom));
            return;
        end
        do
        begin
            case ($urandom_range(0, 4))
                0: a = ACT_QUERY_FEAT;
                1: a = ACT_REF_FEAT;
                2: a = ACT_INIT_NBR;
                3: a = ACT_RANDOM;
                default: a = ACT_READ_NBR;
            endcase
            rlim = (a == ACT_REF_FEAT) ? r_cfg : q_cfg;
            clim = (a == ACT_QUERY_FEAT || a == ACT_REF_FEAT) ? d_cfg :
                   (a == ACT_RANDOM) ? i_cfg : k_cfg;
        end
        while (rlim >= 256 && clim >= 16);
        if (clim < 16 && (rlim >= 256 || $urandom_range(0, 1) != 0))
            send(a, 8'($urandom), 4'($urandom_range(clim, 15)), 16'($urandom), 9'($urandom));
        else
            send(a, 8'($urandom_range(rlim, 255)), 4'($urandom), 16'($urandom), 9'($urandom));
    endtask

    task automatic maybe_noise(bit noisy);
        if (noisy && $urandom_range(0, 7) == 0)
            send_noise();
    endtask

    // drop valid and wait until every result is back
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // write all six registers with raw values, one per cycle
    task automatic set_config(logic [8:0] q, logic [8:0] r, logic [8:0] d, logic [8:0] k,
                              logic [8:0] i, logic [8:0] kind);
        logic [8:0] vals [6];
        drain();
        vals = '{q, r, d, k, i, kind};
        for (int x = 0; x < 6; x++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= 3'(x);
            cfg_data  <= vals[x];
            @(posedge clk);
        end
        cfg_we <= 1'b0;
        q_cfg = sat(q, 1, 256);
        r_cfg = sat(r, 1, 256);
        d_cfg = sat(d[4:0], 1, 16);
        k_cfg = sat(k[2:0], 1, 4);
        i_cfg = sat(i[3:0], 0, 8);
    endtask

    // fill every entry in use, run, then read back the neighbor field
    task automatic load_run_read(bit noisy);
        for (int r = 0; r < q_cfg; r++)
            for (int c = 0; c < d_cfg; c++)
            begin
                maybe_noise(noisy);
                send(ACT_QUERY_FEAT, 8'(r), 4'(c), sample_value(), 9'($urandom));
            end
        for (int r = 0; r < r_cfg; r++)
            for (int c = 0; c < d_cfg; c++)
            begin
                maybe_noise(noisy);
                send(ACT_REF_FEAT, 8'(r), 4'(c), sample_value(), 9'($urandom));
            end
        for (int r = 0; r < q_cfg; r++)
            for (int c = 0; c < k_cfg; c++)
            begin
                maybe_noise(noisy);
                send(ACT_INIT_NBR, 8'(r), 4'(c), 16'($urandom), pick_neighbor());
            end
        for (int r = 0; r < q_cfg; r++)
            for (int c = 0; c < i_cfg; c++)
            begin
                maybe_noise(noisy);
                send(ACT_RANDOM, 8'(r), 4'(c), sample_value(), 9'($urandom));
            end
        send(ACT_RUN, 8'($urandom), 4'($urandom), 16'($urandom), 9'($urandom));
        for (int r = 0; r < q_cfg; r++)
            for (int c = 0; c < k_cfg; c++)
            begin
                maybe_noise(noisy);
                send(ACT_READ_NBR, 8'(r), 4'(c), 16'($urandom), 9'($urandom));
            end
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extreme samples, empty and bad neighbors, all offset cases
        set_config(9'd2, 9'd3, 9'd2, 9'd2, 9'd2, 9'd0);
        send(ACT_QUERY_FEAT, 8'd0, 4'd0, 16'h7fff, 9'd0);
        send(ACT_QUERY_FEAT, 8'd0, 4'd1, 16'h8000, 9'd0);
        send(ACT_QUERY_FEAT, 8'd1, 4'd0, 16'h0000, 9'd0);
        send(ACT_QUERY_FEAT, 8'd1, 4'd1, 16'hffff, 9'd0);
        send(ACT_REF_FEAT, 8'd0, 4'd0, 16'h8000, 9'd0);
        send(ACT_REF_FEAT, 8'd0, 4'd1, 16'h7fff, 9'd0);
        send(ACT_REF_FEAT, 8'd1, 4'd0, 16'h0000, 9'd0);
        send(ACT_REF_FEAT, 8'd1, 4'd1, 16'h0001, 9'd0);
        send(ACT_REF_FEAT, 8'd2, 4'd0, 16'd100, 9'd0);
        send(ACT_REF_FEAT, 8'd2, 4'd1, -16'sd100, 9'd0);
        send(ACT_INIT_NBR, 8'd0, 4'd0, 16'd0, 9'd3);
        send(ACT_INIT_NBR, 8'd0, 4'd1, 16'd0, 9'd0);
        send(ACT_INIT_NBR, 8'd1, 4'd0, 16'd0, 9'd4);
        send(ACT_INIT_NBR, 8'd1, 4'd1, 16'd0, 9'd1);
        send(ACT_RANDOM, 8'd0, 4'd0, 16'h7fff, 9'd0);
        send(ACT_RANDOM, 8'd0, 4'd1, 16'h8000, 9'd0);
        send(ACT_RANDOM, 8'd1, 4'd0, 16'h0000, 9'd0);
        send(ACT_RANDOM, 8'd1, 4'd1, 16'hffff, 9'd0);
        send(3'd6, 8'hff, 4'hf, 16'hffff, 9'h1ff);
        send(3'd7, 8'd0, 4'd0, 16'd0, 9'd0);
        send(ACT_QUERY_FEAT, 8'd2, 4'd0, 16'h1234, 9'd0);
        send(ACT_READ_NBR, 8'd0, 4'd2, 16'd0, 9'd0);
        send(ACT_RUN, 8'd0, 4'd0, 16'd0, 9'd0);
        for (int r = 0; r < 2; r++)
            for (int c = 0; c < 2; c++)
                send(ACT_READ_NBR, 8'(r), 4'(c), 16'd0, 9'd0);

        // random small fields with noise mixed in
        while (requests_sent < 400)
        begin
            set_config(9'($urandom_range(1, 8)), 9'($urandom_range(1, 12)),
                       9'($urandom_range(1, 4)), 9'($urandom_range(1, 4)),
                       9'($urandom_range(0, 3)), 9'($urandom_range(0, 1)));
            steady = ($urandom_range(0, 3) == 0);
            load_run_read(1'b1);
            if ($urandom_range(0, 2) == 0)
            begin
                // run again on the result of the last run
                send(ACT_RUN, 8'($urandom), 4'($urandom), 16'($urandom), 9'($urandom));
                for (int c = 0; c < k_cfg; c++)
                    send(ACT_READ_NBR, 8'($urandom_range(0, q_cfg - 1)), 4'(c),
                         16'($urandom), 9'($urandom));
            end
        end
        steady = 1'b0;

        // largest dims, neighbors and passes; values saturate
        set_config(9'd1, 9'd12, 9'd31, 9'd7, 9'd15, 9'd1);
        load_run_read(1'b0);
        // most query and reference rows, smallest everything else; zero dims and neighbors saturate up
        set_config(9'd256, 9'd511, 9'd0, 9'd0, 9'd0, 9'd0);
        load_run_read(1'b1);

        drain();
        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
